[src/ascii_integer_parser_macros.svh]
// Assertion helpers for the ASCII integer parser.
// All checks run on i_clk and are off while i_rst_n is low.
`ifndef ASCII_INTEGER_PARSER_MACROS_SVH
`define ASCII_INTEGER_PARSER_MACROS_SVH

// Same-cycle implication.
`define AIP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/aip_pkg.sv]
package aip_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int OUT_WIDTH   = 32;
    localparam int EXT_WIDTH   = 64;
    localparam int CHAR_WIDTH  = 8;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = 2;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DETECT_BASE = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BASE_SELECT = 1'd1;

    // base_select codes
    localparam logic [1:0] BASE_BIN   = 2'd0;
    localparam logic [1:0] BASE_DEC   = 2'd1;
    localparam logic [1:0] BASE_HEX   = 2'd2;
    localparam logic [1:0] BASE_OTHER = 2'd3;

    // characters
    localparam logic [CHAR_WIDTH-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_WIDTH-1:0] CH_LF      = 8'h0A;
    localparam logic [CHAR_WIDTH-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_WIDTH-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [CHAR_WIDTH-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_ONE     = 8'h31;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_A_LOWER = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CH_B_LOWER = 8'h62;
    localparam logic [CHAR_WIDTH-1:0] CH_F_LOWER = 8'h66;
    localparam logic [CHAR_WIDTH-1:0] CH_X_LOWER = 8'h78;
    localparam logic [CHAR_WIDTH-1:0] CASE_BIT   = 8'h20;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    // encoding matches base_select
    typedef enum logic [1:0] {
        RM_BIN,
        RM_DEC,
        RM_HEX,
        RM_OTHER
    } t_radix;

    typedef struct packed {
        logic       detect_base;
        logic [1:0] base_select;
    } t_cfg;

    typedef struct packed {
        t_phase                 phase;
        t_radix                 radix;
        logic [VALUE_WIDTH-1:0] acc;
        logic                   negative;
    } t_parse;

    localparam t_parse PARSE_CLEAR = '{
        phase:    PH_SKIP,
        radix:    RM_BIN,
        acc:      '0,
        negative: 1'b0
    };

endpackage

[src/aip_char_if.sv]
interface aip_char_if;
    logic                             valid;
    logic                             ready;
    logic [aip_pkg::CHAR_WIDTH-1:0]   char_code;
    logic                             has_char;
    logic                             last;

    modport source (output valid, output char_code, output has_char, output last,
                    input ready);
    modport sink (input valid, input char_code, input has_char, input last,
                  output ready);
endinterface

[src/aip_value_if.sv]
interface aip_value_if;
    logic                               valid;
    logic                               ready;
    logic signed [aip_pkg::OUT_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

[src/aip_cfg.sv]
module aip_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [aip_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [aip_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data,
    output aip_pkg::t_cfg                       o_cfg
);

    logic       r_detect_base;
    logic [1:0] r_base_select;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detect_base <= 1'b0;
            r_base_select <= aip_pkg::BASE_DEC;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                aip_pkg::CFG_DETECT_BASE: r_detect_base <= i_cfg_data[0];
                aip_pkg::CFG_BASE_SELECT: r_base_select <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.detect_base = r_detect_base;
    assign o_cfg.base_select = r_base_select;

endmodule

[src/aip_step.sv]
module aip_step (
    input  aip_pkg::t_parse                  i_state,
    input  aip_pkg::t_cfg                    i_cfg,
    input  logic [aip_pkg::CHAR_WIDTH-1:0]   i_char_code,
    input  logic                             i_has_char,
    input  logic                             i_last,
    output aip_pkg::t_parse                  o_state,
    output logic signed [aip_pkg::OUT_WIDTH-1:0] o_value
);

    localparam int VW = aip_pkg::VALUE_WIDTH;

    // Append c as a digit of the current radix, or stop the parse.
    function automatic aip_pkg::t_parse f_take(input aip_pkg::t_parse s,
                                               input logic [aip_pkg::CHAR_WIDTH-1:0] c);
        aip_pkg::t_parse r;
        logic [aip_pkg::CHAR_WIDTH-1:0] lc;
        logic            is_dec;
        logic            is_alpha;
        logic            ok;
        logic [3:0]      d;
        logic [VW-1:0]   acc;
        r        = s;
        lc       = c | aip_pkg::CASE_BIT;
        is_dec   = (c >= aip_pkg::CH_ZERO) && (c <= aip_pkg::CH_NINE);
        is_alpha = (lc >= aip_pkg::CH_A_LOWER) && (lc <= aip_pkg::CH_F_LOWER);
        d        = is_dec ? c[3:0] : 4'(lc[3:0] + 4'd9);
        ok       = 1'b0;
        acc      = s.acc;
        case (s.radix)
            aip_pkg::RM_BIN: begin
                ok  = (c == aip_pkg::CH_ZERO) || (c == aip_pkg::CH_ONE);
                acc = {s.acc[VW-2:0], c[0]};
            end
            aip_pkg::RM_DEC: begin
                ok  = is_dec;
                acc = (s.acc << 3) + (s.acc << 1) + VW'(c[3:0]);
            end
            aip_pkg::RM_HEX: begin
                ok  = is_dec || is_alpha;
                acc = {s.acc[VW-5:0], d};
            end
            default: ok = 1'b0;
        endcase
        if (ok) begin
            r.acc   = acc;
            r.phase = aip_pkg::PH_DIGITS;
        end else begin
            r.phase = aip_pkg::PH_DONE;
        end
        return r;
    endfunction

    logic [aip_pkg::CHAR_WIDTH-1:0] lc;
    logic                   is_space;
    logic                   is_b;
    logic                   is_dollar;
    logic                   is_zero;
    logic                   hex16;
    aip_pkg::t_parse        first;
    aip_pkg::t_parse        n_state;
    logic [VW-1:0]          v;
    logic signed [VW-1:0]   v_s;
    logic signed [aip_pkg::EXT_WIDTH-1:0] v_ext;

    assign lc        = i_char_code | aip_pkg::CASE_BIT;
    assign is_space  = (i_char_code == aip_pkg::CH_TAB) || (i_char_code == aip_pkg::CH_LF)
                    || (i_char_code == aip_pkg::CH_CR) || (i_char_code == aip_pkg::CH_SPACE);
    assign is_b      = (lc == aip_pkg::CH_B_LOWER);
    assign is_dollar = (i_char_code == aip_pkg::CH_DOLLAR);
    assign is_zero   = (i_char_code == aip_pkg::CH_ZERO);
    assign hex16     = (i_cfg.base_select == aip_pkg::BASE_HEX);

    // first character after the whitespace: radix and prefix selection
    always_comb begin
        first          = aip_pkg::PARSE_CLEAR;
        first.acc      = '0;
        first.negative = 1'b0;
        if (hex16 || (i_cfg.detect_base && (is_dollar || is_zero))) begin
            first.radix = (hex16 || is_dollar) ? aip_pkg::RM_HEX
                                               : aip_pkg::t_radix'(i_cfg.base_select);
            if (is_dollar) begin
                first.phase = aip_pkg::PH_DIGITS;
            end else if (is_zero) begin
                first.phase = aip_pkg::PH_ZERO;
            end else begin
                first = f_take(first, i_char_code);
            end
        end else if ((i_cfg.base_select == aip_pkg::BASE_BIN)
                     || (i_cfg.detect_base && is_b)) begin
            first.radix = aip_pkg::RM_BIN;
            if (is_b) begin
                first.phase = aip_pkg::PH_DIGITS;
            end else begin
                first = f_take(first, i_char_code);
            end
        end else if (i_cfg.base_select == aip_pkg::BASE_DEC) begin
            first.radix = aip_pkg::RM_DEC;
            if ((i_char_code == aip_pkg::CH_MINUS) || (i_char_code == aip_pkg::CH_PLUS)) begin
                first.negative = (i_char_code == aip_pkg::CH_MINUS);
                first.phase    = aip_pkg::PH_DIGITS;
            end else begin
                first = f_take(first, i_char_code);
            end
        end else begin
            first.radix = aip_pkg::RM_OTHER;
            first.phase = aip_pkg::PH_DONE;
        end
    end

    always_comb begin
        n_state = i_state;
        if (i_has_char) begin
            case (i_state.phase)
                aip_pkg::PH_SKIP: begin
                    if (!is_space) begin
                        n_state = first;
                    end
                end
                aip_pkg::PH_ZERO: begin
                    if (lc == aip_pkg::CH_X_LOWER) begin
                        n_state.radix = aip_pkg::RM_HEX;
                        n_state.phase = aip_pkg::PH_DIGITS;
                    end else begin
                        n_state = f_take(i_state, i_char_code);
                    end
                end
                aip_pkg::PH_DIGITS: n_state = f_take(i_state, i_char_code);
                default: ;
            endcase
        end
        if (i_last) begin
            o_state = aip_pkg::PARSE_CLEAR;
        end else begin
            o_state = n_state;
        end
    end

    // result: wrapped magnitude, optional negate, sign-extend to the port width
    always_comb begin
        v = (n_state.phase == aip_pkg::PH_SKIP) ? '0 : n_state.acc;
        if (n_state.negative) begin
            v = VW'(~v + 1'b1);
        end
        v_s     = v;
        v_ext   = aip_pkg::EXT_WIDTH'(v_s);
        o_value = v_ext[aip_pkg::OUT_WIDTH-1:0];
    end

endmodule

[src/ascii_integer_parser.sv]
// ASCII integer parser.
// i_char (sink) takes one character per request: char_code, has_char and
// last. has_char low is an empty request; last marks the end of a string.
// o_value (source) gives one signed 32-bit value per string, on its last
// request. Registers are written through i_cfg_we / i_cfg_index /
// i_cfg_data: index 0 detect_base, index 1 base_select; write them only
// while no string is in flight.
// Result path: the last character is accepted into the input register, then the
// parse step writes the output register and o_value.valid rises.
// Throughput: one character per cycle unless stalled; the per-character
// step (shift, multiply by ten as shift-add, digit add) sits between the input
// register and the parse state / output register.
// Reset: parse state clears to whitespace skipping, detect_base = 0,
// base_select = decimal, both stages empty.
// Stall: a held result keeps the output register; the input register fills,
// holds its character and i_char.ready stays low until o_value.ready returns.
`include "ascii_integer_parser_macros.svh"

module ascii_integer_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [aip_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [aip_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data,
    aip_char_if.sink                            i_char,
    aip_value_if.source                         o_value
);

    aip_pkg::t_cfg   cfg;
    aip_pkg::t_parse r_state;
    aip_pkg::t_parse n_state;

    logic                           r_in_valid;
    logic [aip_pkg::CHAR_WIDTH-1:0] r_char_code;
    logic                           r_has_char;
    logic                           r_last;
    logic                           r_out_valid;
    logic signed [aip_pkg::OUT_WIDTH-1:0] r_out_value;
    logic signed [aip_pkg::OUT_WIDTH-1:0] n_value;

    logic adv;
    logic consume;

    aip_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    aip_step u_step (
        .i_state     (r_state),
        .i_cfg       (cfg),
        .i_char_code (r_char_code),
        .i_has_char  (r_has_char),
        .i_last      (r_last),
        .o_state     (n_state),
        .o_value     (n_value)
    );

    assign adv          = !r_out_valid || o_value.ready;
    assign consume      = r_in_valid && adv;
    assign i_char.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= aip_pkg::PARSE_CLEAR;
        end else begin
            if (i_char.ready) begin
                r_in_valid <= i_char.valid;
            end
            if (consume) begin
                r_state <= n_state;
            end
            if (adv) begin
                r_out_valid <= consume && r_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.ready && i_char.valid) begin
            r_char_code <= i_char.char_code;
            r_has_char  <= i_char.has_char;
            r_last      <= i_char.last;
        end
        if (consume && r_last) begin
            r_out_value <= n_value;
        end
    end

    assign o_value.valid = r_out_valid;
    assign o_value.value = r_out_value;

    `AIP_ASSERT_NEXT(a_result_on_last, consume && r_last, r_out_valid, "last request gave no result")
    `AIP_ASSERT_NEXT(a_clear_after_last, consume && r_last, r_state == aip_pkg::PARSE_CLEAR, "parse state not cleared after last request")
    `AIP_ASSERT_NOW(a_skip_is_clean, r_state.phase == aip_pkg::PH_SKIP, r_state.acc == '0 && !r_state.negative, "dirty accumulator while skipping whitespace")
    `AIP_ASSERT_NEXT(a_input_held, r_in_valid && !adv, r_in_valid && $stable(r_char_code) && $stable(r_last), "input register changed while stalled")

endmodule

[sim/tb_ascii_integer_parser.sv]
module tb_ascii_integer_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import aip_pkg::*;

    typedef struct {
        logic [CHAR_WIDTH-1:0] code;
        logic                  has;
        logic                  is_last;
    } char_req_t;

    localparam int RANDOM_REQUESTS = 440;
    localparam int SETTLE_CYCLES   = 4;
    localparam logic [CHAR_WIDTH-1:0] BLANKS [4] = '{CH_TAB, CH_LF, CH_CR, CH_SPACE};

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index = CFG_DETECT_BASE;
    logic [CFG_DATA_WIDTH-1:0]  i_cfg_data  = '0;

    aip_char_if  char_bus();
    aip_value_if value_bus();

    ascii_integer_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_char      (char_bus),
        .o_value     (value_bus)
    );

    char_req_t                   pending_chars[$];
    logic signed [OUT_WIDTH-1:0] expected_values[$];

    t_cfg   cfg_shadow = '{detect_base: 1'b0, base_select: BASE_DEC};
    t_parse parse_st   = PARSE_CLEAR;

    bit          idle_on = 1'b1;
    int unsigned send_gap;
    int unsigned stall_left;
    int unsigned error_count;
    int unsigned checked_count;
    int unsigned request_count;
    int unsigned setting_count = 1;
    int unsigned queued_random;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------- predictor ----------------

    function automatic void take_digit(input logic [CHAR_WIDTH-1:0] c);
        logic [CHAR_WIDTH-1:0] folded;
        bit                    ok;
        folded = c | CASE_BIT;
        ok     = 1'b0;
        case (parse_st.radix)
            RM_BIN: if (c == CH_ZERO || c == CH_ONE) begin
                parse_st.acc = {parse_st.acc[VALUE_WIDTH-2:0], c[0]};
                ok = 1'b1;
            end
            RM_DEC: if (c >= CH_ZERO && c <= CH_NINE) begin
                parse_st.acc = parse_st.acc * 10 + VALUE_WIDTH'(c - CH_ZERO);
                ok = 1'b1;
            end
            RM_HEX: begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    parse_st.acc = {parse_st.acc[VALUE_WIDTH-5:0], 4'(c - CH_ZERO)};
                    ok = 1'b1;
                end else if (folded >= CH_A_LOWER && folded <= CH_F_LOWER) begin
                    parse_st.acc = {parse_st.acc[VALUE_WIDTH-5:0],
                                    4'(folded - CH_A_LOWER + 8'd10)};
                    ok = 1'b1;
                end
            end
            default: ;
        endcase
        if (ok)
            parse_st.phase = PH_DIGITS;
        else
            parse_st.phase = PH_DONE;
    endfunction

    // registers are only looked at here, on the first non-blank character
    function automatic void start_number(input logic [CHAR_WIDTH-1:0] c);
        bit hex16;
        bit det;
        bit is_b;
        hex16 = (cfg_shadow.base_select == BASE_HEX);
        det   = cfg_shadow.detect_base;
        is_b  = ((c | CASE_BIT) == CH_B_LOWER);
        parse_st.acc      = '0;
        parse_st.negative = 1'b0;
        if (hex16 || (det && (c == CH_DOLLAR || c == CH_ZERO))) begin
            if (hex16 || c == CH_DOLLAR)
                parse_st.radix = RM_HEX;
            else
                parse_st.radix = t_radix'(cfg_shadow.base_select);
            if (c == CH_DOLLAR)
                parse_st.phase = PH_DIGITS;
            else if (c == CH_ZERO)
                parse_st.phase = PH_ZERO;
            else
                take_digit(c);
        end else if (cfg_shadow.base_select == BASE_BIN || (det && is_b)) begin
            parse_st.radix = RM_BIN;
            if (is_b)
                parse_st.phase = PH_DIGITS;
            else
                take_digit(c);
        end else if (cfg_shadow.base_select == BASE_DEC) begin
            parse_st.radix = RM_DEC;
            if (c == CH_MINUS || c == CH_PLUS) begin
                parse_st.negative = (c == CH_MINUS);
                parse_st.phase    = PH_DIGITS;
            end else begin
                take_digit(c);
            end
        end else begin
            parse_st.radix = RM_OTHER;
            parse_st.phase = PH_DONE;
        end
    endfunction

    // returns 1 when the request closes a string; v then holds the parsed value
    function automatic bit parse_char(input logic [CHAR_WIDTH-1:0] c, input logic has,
                                      input logic fin, output logic signed [OUT_WIDTH-1:0] v);
        logic [VALUE_WIDTH-1:0] mag;
        v = '0;
        if (has) begin
            case (parse_st.phase)
                PH_SKIP:
                    if (!(c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_SPACE))
                        start_number(c);
                PH_ZERO:
                    if ((c | CASE_BIT) == CH_X_LOWER) begin
                        parse_st.radix = RM_HEX;
                        parse_st.phase = PH_DIGITS;
                    end else begin
                        take_digit(c);
                    end
                PH_DIGITS: take_digit(c);
                default: ;
            endcase
        end
        if (!fin)
            return 1'b0;
        mag = (parse_st.phase == PH_SKIP) ? '0 : parse_st.acc;
        v = parse_st.negative ? -mag : mag;
        parse_st = PARSE_CLEAR;
        return 1'b1;
    endfunction

    // ---------------- driver, sink, monitor ----------------

    always @(posedge i_clk) begin : char_driver
        char_req_t req;
        if (!i_rst_n) begin
            char_bus.valid <= 1'b0;
            send_gap       <= 0;
        end else if (!char_bus.valid || char_bus.ready) begin
            if (send_gap != 0) begin
                char_bus.valid <= 1'b0;
                send_gap       <= send_gap - 1;
            end else if (pending_chars.size() != 0) begin
                req = pending_chars.pop_front();
                char_bus.valid     <= 1'b1;
                char_bus.char_code <= req.code;
                char_bus.has_char  <= req.has;
                char_bus.last      <= req.is_last;
                if (idle_on && $urandom_range(0, 3) == 0)
                    send_gap <= $urandom_range(1, 6);
            end else begin
                char_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : value_sink
        if (!i_rst_n) begin
            value_bus.ready <= 1'b0;
            stall_left      <= 0;
        end else if (stall_left != 0) begin
            value_bus.ready <= 1'b0;
            stall_left      <= stall_left - 1;
        end else begin
            value_bus.ready <= 1'b1;
            if (idle_on && $urandom_range(0, 4) == 0)
                stall_left <= $urandom_range(1, 6);
        end
    end

    always @(posedge i_clk) begin : monitor
        logic signed [OUT_WIDTH-1:0] want;
        if (i_rst_n) begin
            if (char_bus.valid && char_bus.ready) begin
                request_count++;
                if (parse_char(char_bus.char_code, char_bus.has_char, char_bus.last, want))
                    expected_values.push_back(want);
            end
            if (value_bus.valid && value_bus.ready) begin
                if (expected_values.size() == 0) begin
                    $error("value: no result expected, got %0d", value_bus.value);
                    error_count++;
                end else begin
                    want = expected_values.pop_front();
                    checked_count++;
                    if (value_bus.value !== want) begin
                        $error("value: expected %0d, got %0d", want, value_bus.value);
                        error_count++;
                    end
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic push_item(input logic [CHAR_WIDTH-1:0] code, input logic has,
                             input logic fin);
        char_req_t item;
        item.code    = code;
        item.has     = has;
        item.is_last = fin;
        pending_chars.push_back(item);
    endtask

    task automatic push_text(input string s);
        if (s.len() == 0) begin
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end else begin
            for (int i = 0; i < s.len(); i++)
                push_item(s[i], 1'b1, i == s.len() - 1);
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_chars.size() != 0 || char_bus.valid || expected_values.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic det, input logic [1:0] base);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DETECT_BASE;
        i_cfg_data  <= CFG_DATA_WIDTH'(det);
        @(posedge i_clk);
        i_cfg_index <= CFG_BASE_SELECT;
        i_cfg_data  <= base;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_shadow.detect_base = det;
        cfg_shadow.base_select = base;
        setting_count++;
    endtask

    function automatic logic [CHAR_WIDTH-1:0] random_digit(input t_radix kind);
        int unsigned pick;
        case (kind)
            RM_BIN: return CH_ZERO + 8'($urandom_range(0, 1));
            RM_DEC: return CH_ZERO + 8'($urandom_range(0, 9));
            default: begin
                pick = $urandom_range(0, 21);
                if (pick < 10)
                    return CH_ZERO + 8'(pick);
                else if (pick < 16)
                    return CH_A_LOWER + 8'(pick - 10);
                else
                    return (CH_A_LOWER & ~CASE_BIT) + 8'(pick - 16);
            end
        endcase
    endfunction

    // mostly well-formed numbers for the current base, some junk and cut-off strings
    task automatic queue_random_string();
        char_req_t   text[$];
        char_req_t   item;
        t_radix      digits;
        int unsigned max_len;
        item.has     = 1'b1;
        item.is_last = 1'b0;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) begin
                item.code = 8'($urandom_range(0, 255));
                item.has  = ($urandom_range(0, 3) != 0);
                text.push_back(item);
            end
        end else begin
            repeat ($urandom_range(0, 2)) begin
                item.code = BLANKS[$urandom_range(0, 3)];
                text.push_back(item);
            end
            if (cfg_shadow.base_select == BASE_OTHER)
                digits = RM_DEC;
            else
                digits = t_radix'(cfg_shadow.base_select);
            case ($urandom_range(0, 7))
                3: begin
                    item.code = CH_ZERO;
                    text.push_back(item);
                    item.code = $urandom_range(0, 1) ? CH_X_LOWER : (CH_X_LOWER & ~CASE_BIT);
                    text.push_back(item);
                    digits = RM_HEX;
                end
                4: begin
                    item.code = CH_DOLLAR;
                    text.push_back(item);
                    digits = RM_HEX;
                end
                5: begin
                    item.code = $urandom_range(0, 1) ? CH_B_LOWER : (CH_B_LOWER & ~CASE_BIT);
                    text.push_back(item);
                    digits = RM_BIN;
                end
                6: begin
                    item.code = CH_MINUS;
                    text.push_back(item);
                end
                7: begin
                    item.code = CH_PLUS;
                    text.push_back(item);
                end
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0)
                digits = t_radix'($urandom_range(0, 2));
            max_len = (digits == RM_BIN) ? 36 : (digits == RM_DEC) ? 12 : 10;
            repeat ($urandom_range(0, max_len)) begin
                item.code = random_digit(digits);
                text.push_back(item);
            end
            if ($urandom_range(0, 3) == 0) begin
                item.code = 8'($urandom_range(0, 255));
                text.insert($urandom_range(0, text.size()), item);
            end
            if ($urandom_range(0, 7) == 0) begin
                item.code = 8'($urandom_range(0, 255));
                item.has  = 1'b0;
                text.insert($urandom_range(0, text.size()), item);
            end
        end
        if (text.size() == 0) begin
            item.code = 8'($urandom_range(0, 255));
            item.has  = 1'b0;
            text.push_back(item);
        end
        text[text.size() - 1].is_last = 1'b1;
        foreach (text[i])
            pending_chars.push_back(text[i]);
        queued_random += text.size();
    endtask

    initial begin
        char_bus.valid     = 1'b0;
        char_bus.char_code = '0;
        char_bus.has_char  = 1'b0;
        char_bus.last      = 1'b0;
        value_bus.ready    = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // settings after reset: decimal, no prefix detection
        @(negedge i_clk);
        push_text(" \t\r\n-2147483648");
        push_text("+42");
        push_text("");
        push_text(" \t ");
        push_text("4294967296");
        push_text("99999999999");
        push_text("12a34");
        push_text("-");
        push_text("0x1F");
        push_item(CH_ONE, 1'b1, 1'b0);
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(CH_NINE, 1'b1, 1'b1);

        wait_idle();
        set_config(1'b1, BASE_OTHER);
        @(negedge i_clk);
        push_text("0x7fffffff");
        push_text("$FFFFFFFF");
        push_text("b1011");
        push_text("0x");
        push_text("7");
        push_text("0Z");

        wait_idle();
        set_config(1'b0, BASE_HEX);
        @(negedge i_clk);
        push_text("0XdeadBEEF");
        push_text("b12");
        push_text("$ff");
        push_text("123456789");

        wait_idle();
        set_config(1'b0, BASE_BIN);
        @(negedge i_clk);
        push_text("B101");
        push_text("B111111111111111111111111111111111");
        push_text("102");
        push_text("0x1");

        wait_idle();
        set_config(1'b1, BASE_DEC);
        @(negedge i_clk);
        push_text("-0x10");
        push_text("0x10");
        push_text("00123");
        push_item(8'h00, 1'b1, 1'b1);
        push_item(8'hFF, 1'b1, 1'b1);

        // random part: all eight settings first, then random ones
        for (int p = 0; p < 8 || queued_random < RANDOM_REQUESTS; p++) begin
            wait_idle();
            if (p < 8)
                set_config(p[0], p[2:1]);
            else
                set_config(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            @(negedge i_clk);
            if (queued_random > RANDOM_REQUESTS * 4 / 5)
                idle_on = 1'b0;
            repeat (4) queue_random_string();
        end

        wait_idle();
        $display("Checked %0d parsed values from %0d character requests over %0d settings",
                 checked_count, request_count, setting_count);
        $display("Bases binary, decimal, hex and other, prefix detection on and off");
        if (error_count == 0 && expected_values.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
